// File: rtl/dfse_pkg.sv
// Shared types and constants of the DFSA frame size estimator.
// No dependencies; the estimator imports this package and dfse_out_if uses its widths.
`default_nettype none
package dfse_pkg;

  localparam int OUT_W      = 13;
  localparam int INIT_W     = 13;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int GAMMA_W = 23;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = 40;
  localparam int ENT_W   = 17;
  localparam int DIV_N_W = 56;
  localparam int DIV_D_W = 33;

  localparam logic [GAMMA_W-1:0] Q_ONE       = 23'd65536;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 23'd131072;
  localparam logic [GAMMA_W-1:0] GAMMA_MAX   = 23'd4194304;
  localparam logic [GAMMA_W-1:0] X_MAX       = 23'd8388607;
  localparam logic [63:0]        EXP_STEP    = 64'd4228380000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROTOCOL   = 2'd0,
    REG_INIT_FRAME = 2'd1,
    REG_THRESHOLD  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OC_EMPTY    = 2'd0,
    OC_SINGLE   = 2'd1,
    OC_COLL     = 2'd2,
    OC_RESERVED = 2'd3
  } outcome_t;

  typedef enum logic {
    MODE_SLOT    = 1'b0,
    MODE_RESTART = 1'b1
  } mode_t;

  typedef enum logic {
    PROTO_LOWER  = 1'b0,
    PROTO_EOMLEE = 1'b1
  } proto_t;

endpackage
`default_nettype wire

// File: rtl/dfse_in_if.sv
// Request channel of slot outcomes (valid/ready handshake).
// No dependencies.
`default_nettype none
interface dfse_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [1:0] slot_outcome;
  modport source (output valid, mode, slot_outcome, input ready);
  modport sink   (input valid, mode, slot_outcome, output ready);
endinterface
`default_nettype wire

// File: rtl/dfse_out_if.sv
// Result channel carrying the next frame size and the slot counts.
// Depends on dfse_pkg for field widths.
`default_nettype none
interface dfse_out_if;
  logic                       valid;
  logic                       ready;
  logic [dfse_pkg::OUT_W-1:0] next_frame;
  logic [dfse_pkg::OUT_W-1:0] empty_slots;
  logic [dfse_pkg::OUT_W-1:0] success_slots;
  logic [dfse_pkg::OUT_W-1:0] collision_slots;
  modport source (output valid, next_frame, empty_slots, success_slots, collision_slots,
                  input ready);
  modport sink   (input valid, next_frame, empty_slots, success_slots, collision_slots,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/dfse_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; used by the estimator top level.
`default_nettype none
module dfse_div #(
  parameter int N = 56,
  parameter int D = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [N-1:0] quotient
);
  localparam int CW = $clog2(N + 1);

  logic [CW-1:0] cnt_r;
  logic [D-1:0]  rem_r;
  logic [D-1:0]  div_r;
  logic [N-1:0]  quo_r;
  logic          busy_r;
  logic          done_r;
  logic [D:0]    shift_w;
  logic [D:0]    diff_w;
  logic          ge_w;

  assign shift_w = {rem_r, quo_r[N-1]};
  assign ge_w    = shift_w >= {1'b0, div_r};
  assign diff_w  = shift_w - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
        rem_r  <= '0;
        quo_r  <= dividend;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge_w ? diff_w[D-1:0] : shift_w[D-1:0];
        quo_r <= {quo_r[N-2:0], ge_w};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");

endmodule
`default_nettype wire

// File: rtl/dfsa_frame_size_estimator.sv
// DFSA frame size estimator: counts slot outcomes and picks the next frame size.
// Depends on dfse_pkg, dfse_in_if, dfse_out_if and dfse_div.
//
// At the last slot of a frame the lower-bound estimator goes from S_EST
// straight to S_DONE. The Eom-Lee estimator runs up to MAX_ITER gamma
// updates, paced by the shared bit-serial divider (up to two divisions per
// update) and the one shared 23x17 multiplier; with zero collisions it
// skips the updates and reports the configured initial frame size.
// Requests are not taken while an estimate runs or while a finished result
// waits for the output register to free.
`default_nettype none
module dfsa_frame_size_estimator #(
  parameter int MAX_FRAME      = 4096,
  parameter int MAX_ITER       = 16,
  parameter int EXP_TABLE_SIZE = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dfse_in_if.sink                         in_ch,
  dfse_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [dfse_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dfse_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dfse_pkg::*;

  localparam int FW  = $clog2(MAX_FRAME + 1);
  localparam int IW  = $clog2(EXP_TABLE_SIZE);
  localparam int ITW = $clog2(MAX_ITER + 1);
  localparam logic [FW-1:0] MAX_F = FW'(MAX_FRAME);

  typedef logic [ENT_W-1:0] exp_tab_t [EXP_TABLE_SIZE];

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] acc;
    acc = 64'h1_0000_0000;
    for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
      t[k] = ENT_W'((acc + 64'd32768) >> 16);
      acc  = (acc * EXP_STEP + 64'd2147483648) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  typedef enum logic [3:0] {
    S_IDLE, S_EST, S_MUL_N, S_DIV_X, S_WAIT_X, S_LOOK, S_MUL_XA, S_MUL_XE,
    S_DEN, S_WAIT_R, S_UPD, S_MUL_F, S_FIN, S_DONE
  } state_t;

  function automatic logic [FW-1:0] sat_next(logic [31:0] v, logic [FW-1:0] sf);
    if (v == 32'd0) return sf;
    if (v > 32'(MAX_FRAME)) return MAX_F;
    return FW'(v);
  endfunction

  state_t              state_r;
  logic                proto_r;
  logic [INIT_W-1:0]   init_r;
  logic [THR_W-1:0]    thr_r;
  logic [FW-1:0]       frame_r, slot_r, empty_r, succ_r, coll_r, next_r;
  logic [FW-1:0]       slot_nxt, start_f;
  logic [GAMMA_W-1:0]  gamma_r, gnew_r, x_r, diff_w;
  logic [ENT_W-1:0]    e_r, a_w;
  logic [PROD_W-1:0]   prod_r, num_r;
  logic [GAMMA_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [ITW-1:0]      iter_r;
  logic [12:0]         idx_w;
  logic signed [41:0]  den_w;
  logic                den_pos;
  logic                div_start, div_busy, div_done;
  logic [DIV_N_W-1:0]  div_num, div_q;
  logic [DIV_D_W-1:0]  div_den;
  logic                acc_w;
  logic                out_valid_r;
  logic [OUT_W-1:0]    o_next_r, o_empty_r, o_succ_r, o_coll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r <= 1'b1;
      init_r  <= INIT_W'(64);
      thr_r   <= THR_W'(66);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PROTOCOL:   proto_r <= cfg_wdata[0];
        REG_INIT_FRAME: init_r  <= cfg_wdata[INIT_W-1:0];
        REG_THRESHOLD:  thr_r   <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (init_r == '0) start_f = FW'(1);
    else if (32'(init_r) > 32'(MAX_FRAME)) start_f = MAX_F;
    else start_f = FW'(init_r);
  end

  assign slot_nxt = slot_r + FW'(1);
  assign idx_w    = x_r[GAMMA_W-1:10];
  assign a_w      = ENT_W'(Q_ONE) - e_r;
  assign den_w    = $signed({9'b0, a_w, 16'b0}) - $signed({2'b0, prod_r});
  assign den_pos  = !den_w[41] && (den_w != '0);
  assign diff_w   = (gamma_r > gnew_r) ? gamma_r - gnew_r : gnew_r - gamma_r;
  assign acc_w    = in_ch.valid && in_ch.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL_N, S_MUL_F: begin
        mul_a = gamma_r;
        mul_b = MUL_B_W'(coll_r);
      end
      S_MUL_XA: begin
        mul_a = x_r;
        mul_b = a_w;
      end
      S_MUL_XE: begin
        mul_a = x_r;
        mul_b = e_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_DIV_X: begin
        div_start = 1'b1;
        div_num   = DIV_N_W'(prod_r) + (DIV_N_W'(succ_r) << 16);
        div_den   = DIV_D_W'(frame_r);
      end
      S_DEN: begin
        div_start = den_pos;
        div_num   = {num_r, 16'b0};
        div_den   = den_w[DIV_D_W-1:0];
      end
      default: ;
    endcase
  end

  dfse_div #(.N(DIV_N_W), .D(DIV_D_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_r     <= (MAX_FRAME < 64) ? MAX_F : FW'(64);
      slot_r      <= '0;
      empty_r     <= '0;
      succ_r      <= '0;
      coll_r      <= '0;
      gamma_r     <= GAMMA_RESET;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc_w) begin
            if (in_ch.mode == MODE_RESTART) begin
              frame_r <= start_f;
              slot_r  <= '0;
              empty_r <= '0;
              succ_r  <= '0;
              coll_r  <= '0;
            end else if (in_ch.slot_outcome != OC_RESERVED) begin
              case (in_ch.slot_outcome)
                OC_EMPTY:  empty_r <= empty_r + FW'(1);
                OC_SINGLE: succ_r  <= succ_r + FW'(1);
                default:   coll_r  <= coll_r + FW'(1);
              endcase
              slot_r <= slot_nxt;
              if (slot_nxt >= frame_r) state_r <= S_EST;
            end
          end
        end
        S_EST: begin
          iter_r <= '0;
          if (proto_r == PROTO_LOWER) begin
            next_r  <= sat_next(32'(coll_r) << 1, start_f);
            state_r <= S_DONE;
          end else if (coll_r == '0) begin
            next_r  <= start_f;
            state_r <= S_DONE;
          end else begin
            state_r <= S_MUL_N;
          end
        end
        S_MUL_N: state_r <= S_DIV_X;
        S_DIV_X: state_r <= S_WAIT_X;
        S_WAIT_X: begin
          if (div_done) begin
            x_r     <= (div_q > DIV_N_W'(X_MAX)) ? X_MAX : div_q[GAMMA_W-1:0];
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          e_r     <= (32'(idx_w) < 32'(EXP_TABLE_SIZE)) ? EXP_TAB[idx_w[IW-1:0]] : '0;
          state_r <= S_MUL_XA;
        end
        S_MUL_XA: state_r <= S_MUL_XE;
        S_MUL_XE: begin
          num_r   <= prod_r;
          state_r <= S_DEN;
        end
        S_DEN: begin
          if (den_pos) begin
            state_r <= S_WAIT_R;
          end else begin
            gnew_r  <= GAMMA_MAX;
            state_r <= S_UPD;
          end
        end
        S_WAIT_R: begin
          if (div_done) begin
            if (div_q < DIV_N_W'(Q_ONE)) gnew_r <= Q_ONE;
            else if (div_q > DIV_N_W'(GAMMA_MAX)) gnew_r <= GAMMA_MAX;
            else gnew_r <= div_q[GAMMA_W-1:0];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          gamma_r <= gnew_r;
          if (diff_w < GAMMA_W'(thr_r) || iter_r == ITW'(MAX_ITER - 1)) begin
            state_r <= S_MUL_F;
          end else begin
            iter_r  <= iter_r + ITW'(1);
            state_r <= S_MUL_N;
          end
        end
        S_MUL_F: state_r <= S_FIN;
        S_FIN: begin
          next_r  <= sat_next(32'((41'(prod_r) + 41'd32768) >> 16), start_f);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            o_next_r    <= OUT_W'(next_r);
            o_empty_r   <= OUT_W'(empty_r);
            o_succ_r    <= OUT_W'(succ_r);
            o_coll_r    <= OUT_W'(coll_r);
            frame_r     <= next_r;
            slot_r      <= '0;
            empty_r     <= '0;
            succ_r      <= '0;
            coll_r      <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.next_frame      = o_next_r;
  assign out_ch.empty_slots     = o_empty_r;
  assign out_ch.success_slots   = o_succ_r;
  assign out_ch.collision_slots = o_coll_r;

  a_gamma_range: assert property (@(posedge clk) disable iff (!rst_n)
    gamma_r >= Q_ONE && gamma_r <= GAMMA_MAX) else $error("gamma out of range");
  a_slot_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> slot_r < frame_r && frame_r != '0)
    else $error("slot index past frame");
  a_iter_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> iter_r <= ITW'(MAX_ITER - 1)) else $error("iteration cap exceeded");
  a_div_waited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT_X || state_r == S_WAIT_R) && !div_done |-> div_busy)
    else $error("waiting on idle divider");

endmodule
`default_nettype wire
